/* hdl/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// Used by wsd_parser and websocket_frame_deframer; depends on nothing else.
package wsd_pkg;

  localparam int LenWidth = 63;

  // Parse phase codes.
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Result kinds.
  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_EMPTY   = 1'b1;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                result_kind;
    logic                fin_flag;
    logic [2:0]          reserved_bits;
    logic [3:0]          frame_opcode;
    logic                masked_flag;
    logic [LenWidth-1:0] payload_length;
    logic                last_of_frame;
  } wsd_result_t;

endpackage

/* hdl/wsd_parser.sv */
// Frame parser state and next-state logic: one stream byte per enabled cycle.
// Depends on wsd_pkg.
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  in_byte,
  input  logic        start_of_message,
  output logic        res_valid,
  output wsd_result_t res
);

  logic [2:0]          phase, phase_next;
  logic [2:0]          ext_count, ext_count_next;
  logic [LenWidth-1:0] len_accum, len_accum_next;
  logic [LenWidth-1:0] remaining, remaining_next;
  logic [31:0]         mask_key, mask_key_next;
  logic [1:0]          key_index, key_index_next;
  // {fin, rsv[2:0], opcode[3:0], mask}
  logic [8:0]          hdr, hdr_next;

  logic [2:0]          phase_eff;
  logic                len_done;
  logic                enter_payload;
  logic [7:0]          key_byte;
  logic [LenWidth-1:0] rem_dec;

  assign phase_eff = start_of_message ? PH_HDR0 : phase;
  assign rem_dec   = remaining - LenWidth'(1);

  always_comb begin
    phase_next     = phase;
    ext_count_next = ext_count;
    len_accum_next = len_accum;
    remaining_next = remaining;
    mask_key_next  = mask_key;
    key_index_next = key_index;
    hdr_next       = hdr;
    len_done       = 1'b0;
    enter_payload  = 1'b0;
    res_valid      = 1'b0;
    key_byte       = 8'd0;
    res.out_byte    = 8'd0;
    res.result_kind = RK_PAYLOAD;
    res.last_of_frame = 1'b0;

    unique case (phase_eff)
      PH_HDR1: begin
        hdr_next[0]    = in_byte[7];
        len_accum_next = '0;
        if (in_byte[6:0] == LEN_CODE_16) begin
          ext_count_next = 3'd1;
          phase_next     = PH_EXT;
        end else if (in_byte[6:0] == LEN_CODE_64) begin
          ext_count_next = 3'd7;
          phase_next     = PH_EXT;
        end else begin
          len_accum_next = LenWidth'(in_byte[6:0]);
          len_done       = 1'b1;
        end
      end
      PH_EXT: begin
        // The top bit of an eight-byte length falls off the 63-bit register.
        len_accum_next = {len_accum[LenWidth-9:0], in_byte};
        if (ext_count == 3'd0) begin
          len_done = 1'b1;
        end else begin
          ext_count_next = ext_count - 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        if (key_index == 2'd3) begin
          enter_payload = 1'b1;
        end else begin
          key_index_next = key_index + 2'd1;
        end
      end
      PH_DATA: begin
        unique case (key_index)
          2'd0:    key_byte = mask_key[31:24];
          2'd1:    key_byte = mask_key[23:16];
          2'd2:    key_byte = mask_key[15:8];
          default: key_byte = mask_key[7:0];
        endcase
        remaining_next    = rem_dec;
        res_valid         = 1'b1;
        res.out_byte      = in_byte ^ key_byte;
        res.last_of_frame = (rem_dec == '0);
        key_index_next    = key_index + 2'd1;
        if (rem_dec == '0) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        hdr_next       = {in_byte[7], in_byte[6:4], in_byte[3:0], 1'b0};
        ext_count_next = 3'd0;
        len_accum_next = '0;
        remaining_next = '0;
        key_index_next = 2'd0;
        phase_next     = PH_HDR1;
      end
    endcase

    // Length complete: an unmasked frame runs with an all-zero key.
    if (len_done) begin
      mask_key_next = 32'd0;
      if (hdr_next[0]) begin
        key_index_next = 2'd0;
        phase_next     = PH_KEY;
      end else begin
        enter_payload = 1'b1;
      end
    end

    if (enter_payload) begin
      key_index_next = 2'd0;
      if (len_accum_next == '0) begin
        remaining_next    = '0;
        phase_next        = PH_HDR0;
        res_valid         = 1'b1;
        res.out_byte      = 8'd0;
        res.result_kind   = RK_EMPTY;
        res.last_of_frame = 1'b1;
      end else begin
        remaining_next = len_accum_next;
        phase_next     = PH_DATA;
      end
    end

    res.fin_flag       = hdr_next[8];
    res.reserved_bits  = hdr_next[7:5];
    res.frame_opcode   = hdr_next[4:1];
    res.masked_flag    = hdr_next[0];
    res.payload_length = len_accum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      ext_count <= 3'd0;
      len_accum <= '0;
      remaining <= '0;
      mask_key  <= 32'd0;
      key_index <= 2'd0;
      hdr       <= 9'd0;
    end else if (en) begin
      phase     <= phase_next;
      ext_count <= ext_count_next;
      len_accum <= len_accum_next;
      remaining <= remaining_next;
      mask_key  <= mask_key_next;
      key_index <= key_index_next;
      hdr       <= hdr_next;
    end
  end

endmodule

/* hdl/websocket_frame_deframer.sv */
// Channel   | Signals                                  | Transfer when
// input     | in_valid, in_ready, in_byte, start_of_message | in_valid && in_ready
// output    | out_valid, out_ready, out_byte .. last_of_frame | out_valid && out_ready
//
// One stream byte is taken per cycle while in_ready is high; its result, if any, appears on the
// output register in the next cycle. Header, length and key bytes give no result,
// except the byte that completes a zero-length frame, which gives the empty-frame result.
// Throughput is set by the single output register: input stalls only while a
// result is held there and out_ready is low. Reset clears the parser to expect
// a first header byte and empties the output register.
// Top level of the WebSocket frame deframer; depends on wsd_pkg and wsd_parser.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                start_of_message,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                result_kind,
  output logic                fin_flag,
  output logic [2:0]          reserved_bits,
  output logic [3:0]          frame_opcode,
  output logic                masked_flag,
  output logic [LenWidth-1:0] payload_length,
  output logic                last_of_frame
);

  logic        accept;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_reg;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  wsd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .en               (accept),
    .in_byte          (in_byte),
    .start_of_message (start_of_message),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= res;
    end
  end

  assign out_byte       = out_reg.out_byte;
  assign result_kind    = out_reg.result_kind;
  assign fin_flag       = out_reg.fin_flag;
  assign reserved_bits  = out_reg.reserved_bits;
  assign frame_opcode   = out_reg.frame_opcode;
  assign masked_flag    = out_reg.masked_flag;
  assign payload_length = out_reg.payload_length;
  assign last_of_frame  = out_reg.last_of_frame;

  // An empty-frame result always closes its frame with a zero byte.
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RK_EMPTY) |->
      last_of_frame && (out_byte == 8'd0) && (payload_length == '0))
    else $error("empty-frame result with bad fields");

  // A payload byte is never reported for a zero-length frame.
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RK_PAYLOAD) |-> (payload_length != '0))
    else $error("payload result with zero length");

  // A forced first header byte produces no result.
  a_hdr_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && start_of_message |=> !out_valid)
    else $error("header byte produced a result");

  // An empty output register never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

/* bench/websocket_frame_deframer_checker.sv */
// Checker for the WebSocket frame deframer: watches both channels, decodes the byte stream
// on its own and compares every result transfer with the oldest decoded byte.
// Depends on wsd_pkg for the result struct, phase codes, length codes and result kinds.
module websocket_frame_deframer_checker import wsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                start_of_message,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [7:0]          out_byte,
  input  logic                result_kind,
  input  logic                fin_flag,
  input  logic [2:0]          reserved_bits,
  input  logic [3:0]          frame_opcode,
  input  logic                masked_flag,
  input  logic [LenWidth-1:0] payload_length,
  input  logic                last_of_frame,
  output int                  errors,
  output int                  pending,
  output int                  payload_results,
  output int                  empty_results
);

  logic [2:0]  parse_phase = PH_HDR0;
  logic [2:0]  ext_left = '0;
  logic [63:0] length_accum = '0;
  logic [63:0] bytes_left = '0;
  logic [31:0] mask_key = '0;
  logic [1:0]  key_index = '0;
  logic        hdr_fin = 1'b0;
  logic [2:0]  hdr_rsv = '0;
  logic [3:0]  hdr_opcode = '0;
  logic        hdr_masked = 1'b0;

  wsd_result_t decoded_q[$];
  int error_cnt = 0;
  int payload_cnt = 0;
  int empty_cnt = 0;

  function automatic wsd_result_t make_result(input logic [7:0] b, input logic kind,
                                              input logic last);
    wsd_result_t r;
    r.out_byte       = b;
    r.result_kind    = kind;
    r.fin_flag       = hdr_fin;
    r.reserved_bits  = hdr_rsv;
    r.frame_opcode   = hdr_opcode;
    r.masked_flag    = hdr_masked;
    r.payload_length = length_accum[LenWidth-1:0];
    r.last_of_frame  = last;
    return r;
  endfunction

  task automatic open_payload(output logic produced, output wsd_result_t res);
    produced = 1'b0;
    res = '0;
    key_index = 2'd0;
    if (length_accum == 64'd0) begin
      bytes_left = '0;
      parse_phase = PH_HDR0;
      res = make_result(8'h00, RK_EMPTY, 1'b1);
      produced = 1'b1;
    end else begin
      bytes_left = length_accum;
      parse_phase = PH_DATA;
    end
  endtask

  task automatic finish_length(output logic produced, output wsd_result_t res);
    produced = 1'b0;
    res = '0;
    // The top bit of a 64-bit length is reserved and simply dropped.
    length_accum[63] = 1'b0;
    // An unmasked frame decodes with an all-zero key.
    mask_key = '0;
    if (hdr_masked) begin
      key_index = 2'd0;
      parse_phase = PH_KEY;
    end else begin
      open_payload(produced, res);
    end
  endtask

  task automatic decode_stream_byte(input logic [7:0] b, input logic som,
                                    output logic produced, output wsd_result_t res);
    logic [2:0] ph;
    logic [7:0] kb;
    produced = 1'b0;
    res = '0;
    ph = som ? PH_HDR0 : parse_phase;
    case (ph)
      PH_HDR1: begin
        hdr_masked = b[7];
        length_accum = '0;
        if (b[6:0] == LEN_CODE_16) begin
          ext_left = 3'd1;
          parse_phase = PH_EXT;
        end else if (b[6:0] == LEN_CODE_64) begin
          ext_left = 3'd7;
          parse_phase = PH_EXT;
        end else begin
          length_accum = {57'd0, b[6:0]};
          finish_length(produced, res);
        end
      end
      PH_EXT: begin
        length_accum = {length_accum[55:0], b};
        if (ext_left == 3'd0) finish_length(produced, res);
        else ext_left = ext_left - 3'd1;
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (key_index == 2'd3) open_payload(produced, res);
        else key_index = key_index + 2'd1;
      end
      PH_DATA: begin
        kb = 8'(mask_key >> (8 * (3 - int'(key_index))));
        bytes_left = bytes_left - 64'd1;
        res = make_result(b ^ kb, RK_PAYLOAD, bytes_left == 64'd0);
        produced = 1'b1;
        key_index = key_index + 2'd1;
        if (bytes_left == 64'd0) parse_phase = PH_HDR0;
      end
      default: begin
        // First header byte; the mask bit arrives with the second one.
        hdr_fin = b[7];
        hdr_rsv = b[6:4];
        hdr_opcode = b[3:0];
        hdr_masked = 1'b0;
        ext_left = '0;
        length_accum = '0;
        bytes_left = '0;
        key_index = '0;
        parse_phase = PH_HDR1;
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [62:0] exp_v,
                                      input logic [62:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_cnt++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    wsd_result_t want;
    logic produced;
    if (rst) begin
      parse_phase = PH_HDR0;
      ext_left = '0;
      length_accum = '0;
      bytes_left = '0;
      mask_key = '0;
      key_index = '0;
      hdr_fin = 1'b0;
      hdr_rsv = '0;
      hdr_opcode = '0;
      hdr_masked = 1'b0;
      decoded_q.delete();
    end else begin
      // The output side goes first: a result never leaves in the cycle its byte enters.
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result transfer with nothing decoded: out_byte 0x%0h", out_byte);
          error_cnt++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", 63'(want.out_byte), 63'(out_byte));
          check_field("result_kind", 63'(want.result_kind), 63'(result_kind));
          check_field("fin_flag", 63'(want.fin_flag), 63'(fin_flag));
          check_field("reserved_bits", 63'(want.reserved_bits), 63'(reserved_bits));
          check_field("frame_opcode", 63'(want.frame_opcode), 63'(frame_opcode));
          check_field("masked_flag", 63'(want.masked_flag), 63'(masked_flag));
          check_field("payload_length", want.payload_length, payload_length);
          check_field("last_of_frame", 63'(want.last_of_frame), 63'(last_of_frame));
          if (want.result_kind == RK_EMPTY) empty_cnt++;
          else payload_cnt++;
        end
      end
      if (in_valid && in_ready) begin
        decode_stream_byte(in_byte, start_of_message, produced, want);
        if (produced) decoded_q.insert(decoded_q.size(), want);
      end
    end
    errors <= error_cnt;
    pending <= decoded_q.size();
    payload_results <= payload_cnt;
    empty_results <= empty_cnt;
  end

endmodule

/* bench/websocket_frame_deframer_tb.sv */
// Top of the deframer testbench: clock, reset, stream stimulus and the final verdict.
// Depends on wsd_pkg, websocket_frame_deframer and websocket_frame_deframer_checker.
module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                start_of_message = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_byte;
  logic                result_kind;
  logic                fin_flag;
  logic [2:0]          reserved_bits;
  logic [3:0]          frame_opcode;
  logic                masked_flag;
  logic [LenWidth-1:0] payload_length;
  logic                last_of_frame;

  int errors;
  int pending;
  int payload_results;
  int empty_results;

  int send_idle_pct = 11;
  int recv_idle_pct = 46;
  int stream_bytes = 0;
  int frames_sent = 0;

  // Directed stream: {start flag, byte}.
  logic [8:0] directed_seq [27] = '{
    // Empty ping frame.
    {1'b1, 8'h89}, {1'b0, 8'h00},
    // Masked two-byte frame with the extreme byte values.
    {1'b1, 8'h81}, {1'b0, 8'h82}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hA5},
    {1'b0, 8'h3C}, {1'b0, 8'h00}, {1'b0, 8'hFF},
    // Non-minimal 16-bit length, cut short by the next start flag.
    {1'b0, 8'h72}, {1'b0, 8'h7E}, {1'b0, 8'h00}, {1'b0, 8'h03}, {1'b0, 8'h12},
    {1'b0, 8'h34},
    // 64-bit length with the reserved top bit set.
    {1'b1, 8'hFF}, {1'b0, 8'h7F}, {1'b0, 8'h80}, {1'b0, 8'h00}, {1'b0, 8'h00},
    {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h01},
    {1'b0, 8'hEE}
  };

  websocket_frame_deframer dut (.*);

  websocket_frame_deframer_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic som);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    start_of_message <= som;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    stream_bytes++;
  endtask

  // Sends one random frame; a frame too long to finish, or cut on purpose, is
  // reported as broken so that the next one starts with the start flag.
  task automatic send_frame(input logic resync, output logic broken);
    logic [7:0]  frame_q[$];
    logic [6:0]  hdr1;
    logic        masked;
    logic [15:0] len16;
    logic [63:0] len64;
    logic [62:0] frame_len;
    int          sel;
    int          n_body;
    int          cut;
    logic        lead_som;
    broken = 1'b0;
    masked = 1'($urandom_range(1));
    sel = $urandom_range(99);
    frame_q.insert(frame_q.size(), 8'($urandom_range(255)));
    if (sel < 60) begin
      hdr1[6:0] = ($urandom_range(9) == 0) ? 7'($urandom_range(125)) : 7'($urandom_range(12));
      frame_len = 63'(hdr1[6:0]);
      frame_q.insert(frame_q.size(), {masked, hdr1[6:0]});
    end else if (sel < 80) begin
      len16 = ($urandom_range(9) == 0) ? 16'($urandom_range(300)) : 16'($urandom_range(20));
      frame_len = 63'(len16);
      frame_q.insert(frame_q.size(), {masked, LEN_CODE_16});
      frame_q.insert(frame_q.size(), len16[15:8]);
      frame_q.insert(frame_q.size(), len16[7:0]);
    end else begin
      len64 = {$urandom, $urandom};
      if ($urandom_range(3) != 0) len64[62:0] = 63'($urandom_range(20));
      frame_len = len64[62:0];
      frame_q.insert(frame_q.size(), {masked, LEN_CODE_64});
      for (int i = 7; i >= 0; i--) frame_q.insert(frame_q.size(), len64[8*i +: 8]);
    end
    if (masked) repeat (4) frame_q.insert(frame_q.size(), 8'($urandom_range(255)));
    if (frame_len > 63'd300) begin
      n_body = $urandom_range(6);
      broken = 1'b1;
    end else begin
      n_body = int'(frame_len);
    end
    repeat (n_body) frame_q.insert(frame_q.size(), 8'($urandom_range(255)));
    if ($urandom_range(99) < 8) begin
      cut = $urandom_range(frame_q.size(), 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
      broken = 1'b1;
    end
    lead_som = resync ? 1'b1 : 1'($urandom_range(1));
    foreach (frame_q[i]) send_byte(frame_q[i], (i == 0) ? lead_som : 1'b0);
    frames_sent++;
  endtask

  initial begin
    logic resync;
    logic broken;
    int   target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);
    frames_sent += 4;

    resync = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 11; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      target = stream_bytes + 350;
      while (stream_bytes < target) begin
        if ($urandom_range(9) == 0) begin
          // Line noise with random start flags.
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
          resync = 1'b1;
        end else begin
          send_frame(resync, broken);
          resync = broken;
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d stream bytes in %0d frames, with noise and cut frames mixed in.",
             stream_bytes, frames_sent);
    $display("Checked %0d payload results and %0d empty-frame results.",
             payload_results, empty_results);
    if (errors == 0 && pending == 0) begin
      $display("websocket_frame_deframer: match");
    end else begin
      $display("websocket_frame_deframer: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out waiting for the deframer.");
    $display("websocket_frame_deframer: mismatch");
    $finish;
  end

endmodule
